// File: design/pcse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_pkg: shared types and codes of the peer clock sync engine
// Message and reply codes, beat structs and the front-to-back command.
// ----------------------------------------------------------------------------
package pcse_pkg;

   typedef enum logic [2:0] {
      OP_HELLO      = 3'd0,
      OP_CONNECT    = 3'd1,
      OP_GET_TIME   = 3'd2,
      OP_DELAY_REQ  = 3'd3,
      OP_SYNC_START = 3'd4,
      OP_DELAY_RESP = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_HDR   = 3'd0,
      KIND_ENTRY = 3'd1,
      KIND_ACK   = 3'd2,
      KIND_TIME  = 3'd3,
      KIND_DRESP = 3'd4,
      KIND_DREQ  = 3'd5,
      KIND_REJ   = 3'd6
   } kind_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] peer_addr;
      logic [15:0] src_port;
      logic [7:0]  msg_level;
      logic [63:0] msg_timestamp;
      logic [63:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  reply_kind;
      logic [31:0] out_addr;
      logic [15:0] out_port;
      logic [7:0]  out_level;
      logic [63:0] out_timestamp;
      logic [5:0]  peer_count;
      logic        last;
   } rsp_type;

   // Classified message handed from front to back.
   typedef struct packed {
      logic [2:0]  op;
      logic [47:0] peer;
      logic [7:0]  level;
      logic [63:0] stamp;
      logic [63:0] now;
   } cmd_type;

endpackage
`default_nettype wire

// File: design/peer_clock_sync_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// peer_clock_sync_engine_core: clock sync message engine
// Peer table, time replies and delay measurement for one message stream.
// ----------------------------------------------------------------------------
// One message is worked at a time: the next is taken only when the engine is
// idle and no reply beat is waiting to be popped. An undefined op is dropped
// at intake. A sync start that passes its level checks walks the peer table
// one entry at a time; a hello emits its header and then one entry beat per
// peer, each once the previous beat has been popped. A two-entry queue in
// front lets new messages arrive while one is being worked.
module peer_clock_sync_engine_core #(
   parameter int PEER_SLOTS     = 32,
   parameter int TOP_SYNC_LEVEL = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcse_pkg::req_type req_data,
   input  wire logic              req_push,
   output logic                   req_full,
   output pcse_pkg::rsp_type      rsp_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop
);
   pcse_pkg::cmd_type cmd_data;
   logic              cmd_valid, cmd_take;

   pcse_front u_front (
      .clock, .reset, .req_data, .req_push, .req_full,
      .cmd_data, .cmd_valid, .cmd_take
   );

   pcse_back #(.PEER_SLOTS(PEER_SLOTS), .TOP_SYNC_LEVEL(TOP_SYNC_LEVEL)) u_back (
      .clock, .reset, .cmd_data, .cmd_valid, .cmd_take,
      .rsp_data, .rsp_empty, .pop(rsp_pop)
   );
endmodule
`default_nettype wire

// File: design/pcse_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_front: message intake
// Accepts request beats, drops undefined ops, and queues commands for the back.
// ----------------------------------------------------------------------------
module pcse_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcse_pkg::req_type req_data,
   input  wire logic              req_push,
   output logic                   req_full,
   output pcse_pkg::cmd_type      cmd_data,
   output logic                   cmd_valid,
   input  wire logic              cmd_take
);
   // two-entry queue
   pcse_pkg::cmd_type q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       acc, keep;

   assign req_full  = (cnt_ff == 2'd2);
   assign acc       = req_push && !req_full;
   assign keep      = acc && (req_data.op <= pcse_pkg::OP_DELAY_RESP);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ keep;
      rd_in  = rd_ff ^ (cmd_take && cmd_valid);
      cnt_in = cnt_ff + {1'b0, keep} - {1'b0, cmd_take && cmd_valid};
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the classified beat
   always_ff @(posedge clock) begin
      if (keep) begin
         q_ff[wr_ff] <= '{op: req_data.op,
                          peer: {req_data.peer_addr, req_data.src_port},
                          level: req_data.msg_level,
                          stamp: req_data.msg_timestamp,
                          now: req_data.now_ms};
      end
   end
endmodule
`default_nettype wire

// File: design/pcse_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_back: protocol engine
// Walks the peer table, keeps sync state and emits reply beats.
// ----------------------------------------------------------------------------
module pcse_back #(
   parameter int PEER_SLOTS     = 32,
   parameter int TOP_SYNC_LEVEL = 255
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pcse_pkg::cmd_type cmd_data,
   input  wire logic              cmd_valid,
   output logic                   cmd_take,
   output pcse_pkg::rsp_type      rsp_data,
   output logic                   rsp_empty,
   input  wire logic              pop
);
   localparam int IW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
   localparam int CW = $clog2(PEER_SLOTS + 1);
   localparam logic [7:0] TOP = 8'(TOP_SYNC_LEVEL);

   typedef enum logic [2:0] {
      S_IDLE, S_LIST, S_LWAIT, S_SCAN, S_SWAIT, S_OFFSET
   } state_type;

   state_type         state_ff;
   pcse_pkg::cmd_type c_ff;
   logic [47:0]       mem [PEER_SLOTS];
   logic [47:0]       rd_ff;
   logic [CW-1:0]     total_ff, idx_ff;
   logic [7:0]        lvl_ff, plvl_ff;
   logic [47:0]       sync_ff, ppeer_ff;
   logic [63:0]       off_ff, lsync_ff, t1_ff, t2_ff, sum_ff;
   logic              await_ff, found_ff;
   pcse_pkg::rsp_type out_ff;
   pcse_pkg::rsp_type beat_in;
   logic              full_ff;
   logic              wr_en, rd_go;
   logic [63:0]       half;

   assign rsp_data  = out_ff;
   assign rsp_empty = !full_ff;
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && !full_ff;
   assign half = sum_ff[63] ? (64'd0 - ((64'd0 - sum_ff) >> 1)) : (sum_ff >> 1);
   assign wr_en = ((state_ff == S_LIST) && (idx_ff == total_ff) ||
                   cmd_take && (cmd_data.op == pcse_pkg::OP_CONNECT))
                  && (total_ff < CW'(PEER_SLOTS));
   assign rd_go = (state_ff == S_LIST || state_ff == S_SCAN) && (idx_ff < total_ff);

   // reply beat for the command being taken
   always_comb begin
      beat_in = '{reply_kind: pcse_pkg::KIND_ACK, out_addr: cmd_data.peer[47:16],
                  out_port: cmd_data.peer[15:0], out_level: 8'd0,
                  out_timestamp: 64'd0, peer_count: 6'd0, last: 1'b1};
      case (cmd_data.op)
         pcse_pkg::OP_HELLO: begin
            beat_in.reply_kind = pcse_pkg::KIND_HDR;
            beat_in.peer_count = 6'(total_ff);
            beat_in.last       = (total_ff == '0);
         end
         pcse_pkg::OP_GET_TIME: begin
            beat_in.reply_kind    = pcse_pkg::KIND_TIME;
            beat_in.out_level     = lvl_ff;
            beat_in.out_timestamp = cmd_data.now - off_ff;
         end
         pcse_pkg::OP_DELAY_REQ: begin
            beat_in.reply_kind    = pcse_pkg::KIND_DRESP;
            beat_in.out_level     = lvl_ff;
            beat_in.out_timestamp = cmd_data.now - off_ff;
         end
         pcse_pkg::OP_DELAY_RESP: beat_in.reply_kind = pcse_pkg::KIND_REJ;
         default: ;
      endcase
   end

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[total_ff[IW-1:0]] <= (state_ff == S_LIST) ? c_ff.peer : cmd_data.peer;
      rd_ff <= mem[idx_ff[IW-1:0]];
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; full_ff <= 1'b0; total_ff <= '0; lvl_ff <= TOP;
         sync_ff <= '0; off_ff <= '0; lsync_ff <= '0; await_ff <= 1'b0;
         ppeer_ff <= '0; plvl_ff <= '0; t1_ff <= '0; t2_ff <= '0;
      end else begin
         if (pop && full_ff) full_ff <= 1'b0;
         if (wr_en) total_ff <= total_ff + CW'(1);
         case (state_ff)
            S_IDLE: if (cmd_take) begin
               c_ff <= cmd_data; idx_ff <= '0; found_ff <= 1'b0;
               out_ff <= beat_in;
               case (cmd_data.op)
                  pcse_pkg::OP_HELLO: begin
                     full_ff <= 1'b1; state_ff <= S_LIST;
                  end
                  pcse_pkg::OP_CONNECT, pcse_pkg::OP_GET_TIME, pcse_pkg::OP_DELAY_REQ:
                     full_ff <= 1'b1;
                  pcse_pkg::OP_SYNC_START: begin
                     if (cmd_data.peer != sync_ff) begin
                        if ({1'b0, cmd_data.level} + 9'd1 < {1'b0, lvl_ff} &&
                            {1'b0, cmd_data.level} + 9'd1 < {1'b0, TOP} && !await_ff)
                           state_ff <= S_SCAN;
                     end else if (cmd_data.level >= lvl_ff) begin
                        lvl_ff <= TOP; lsync_ff <= '0;
                     end else begin
                        lsync_ff <= cmd_data.now;
                        if ({1'b0, cmd_data.level} + 9'd1 < {1'b0, TOP} && !await_ff)
                           state_ff <= S_SCAN;
                     end
                  end
                  pcse_pkg::OP_DELAY_RESP: begin
                     if (cmd_data.peer != ppeer_ff || cmd_data.level != plvl_ff || !await_ff)
                     begin
                        full_ff <= 1'b1;
                     end else begin
                        await_ff <= 1'b0; sync_ff <= ppeer_ff;
                        lvl_ff <= plvl_ff + 8'd1; lsync_ff <= cmd_data.now;
                        sum_ff <= t2_ff - t1_ff + t2_ff - cmd_data.stamp;
                        state_ff <= S_OFFSET;
                     end
                  end
                  default: ;
               endcase
            end
            S_OFFSET: begin
               off_ff <= half; state_ff <= S_IDLE;
            end
            S_LIST: begin
               if (rd_go && !full_ff) begin
                  idx_ff <= idx_ff + CW'(1); state_ff <= S_LWAIT;
               end else if (!rd_go) state_ff <= S_IDLE;
            end
            S_LWAIT: begin
               out_ff <= '{reply_kind: pcse_pkg::KIND_ENTRY, out_addr: rd_ff[47:16],
                           out_port: rd_ff[15:0], out_level: 8'd0, out_timestamp: 64'd0,
                           peer_count: 6'd0, last: (idx_ff == total_ff)};
               full_ff <= 1'b1; state_ff <= S_LIST;
            end
            S_SCAN: begin
               if (rd_go) begin
                  idx_ff <= idx_ff + CW'(1); state_ff <= S_SWAIT;
               end else begin
                  out_ff.reply_kind <= found_ff ? pcse_pkg::KIND_DREQ : pcse_pkg::KIND_REJ;
                  full_ff <= 1'b1; state_ff <= S_IDLE;
                  if (found_ff) begin
                     ppeer_ff <= c_ff.peer; await_ff <= 1'b1; plvl_ff <= c_ff.level;
                     t1_ff <= c_ff.stamp; t2_ff <= c_ff.now;
                  end
               end
            end
            S_SWAIT: begin
               if (rd_ff == c_ff.peer) found_ff <= 1'b1;
               state_ff <= S_SCAN;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: design/pcse_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcse_checker: port-level checks
// Watches the result channel of the engine, and req_full after reset.
// ----------------------------------------------------------------------------
module pcse_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire pcse_pkg::rsp_type rsp_data,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop
);
   // a waiting beat holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result beat changed while waiting");
   // header count and last flag agree
   a_hdr: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.reply_kind == pcse_pkg::KIND_HDR |->
         rsp_data.last == (rsp_data.peer_count == 6'd0))
      else $error("hello header last flag wrong");
   // only time and delay-response replies carry a level
   a_lvl: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.reply_kind != pcse_pkg::KIND_TIME &&
      rsp_data.reply_kind != pcse_pkg::KIND_DRESP |-> rsp_data.out_level == 8'd0)
      else $error("level on wrong reply kind");
   // nothing after reset
   a_rst: assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("state left after reset");
endmodule

bind peer_clock_sync_engine_core pcse_checker u_pcse_checker (
   .clock, .reset, .req_full, .rsp_data, .rsp_empty, .rsp_pop
);
`default_nettype wire
